FILE: hw/rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// types, codes and constants shared by the first-fit block allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned FRAME_BYTES     = 4096;
  localparam int unsigned HEADER_BYTES    = 12;
  localparam int unsigned ALIGN_BYTES     = 8;
  localparam int unsigned MAX_ENTRIES_DEF = 1024;
  localparam int unsigned INIT_REQUEST    = 4096;
  localparam int unsigned REQ_LIMIT       = 4194304;
  localparam logic [23:0] HEAP_BASE_RST   = 24'h400000;
  localparam logic [23:0] HEAP_CEIL_RST   = 24'h800000;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADFREE = 2'd2,
    ST_NULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_INIT,
    CMD_ALLOC,
    CMD_FREE,
    CMD_OOM,
    CMD_NULL,
    CMD_NOP
  } cmd_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_ALN,
    BS_SCAN,
    BS_CHK,
    BS_FRM,
    BS_CARVE,
    BS_DONE
  } bstate_e;

  localparam logic [1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [1:0] REG_HEAP_CEIL = 2'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [22:0] request_size;
    logic [23:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] granted_address;
  } out_item_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [22:0] size;
    logic [23:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [23:0] base;
    logic [22:0] usable;
    logic        used;
  } entry_t;

endpackage

FILE: hw/rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ffa_rem.sv
// ----------------------------------------------------------------------------
// ffa_rem
// rounds a byte count up to a power-of-two unit with an add and a mask
// ----------------------------------------------------------------------------
module ffa_rem #(
  parameter int unsigned UNIT = ffa_pkg::ALIGN_BYTES
) (
  input  logic [23:0] value_i,
  output logic [23:0] rounded_o
);

  localparam logic [23:0] LOW_MASK = 24'(UNIT - 1);

  assign rounded_o = (value_i + LOW_MASK) & ~LOW_MASK;

endmodule

FILE: hw/rtl/ffa_queue.sv
// ----------------------------------------------------------------------------
// ffa_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module ffa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ffa_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          nonempty_o,
  output ffa_pkg::cmd_t pop_data_o
);
  import ffa_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign nonempty_o = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/ffa_front.sv
// ----------------------------------------------------------------------------
// ffa_front
// accepts input transactions and classifies them into back-end commands
// ----------------------------------------------------------------------------
module ffa_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ffa_pkg::in_item_t in_item_i,
  input  logic              full_i,
  output logic              push_o,
  output ffa_pkg::cmd_t     cmd_o
);
  import ffa_pkg::*;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.size = in_item_i.request_size;
    cmd_o.addr = in_item_i.release_address;
    unique case (mode_e'(in_item_i.mode))
      MODE_INIT:  cmd_o.cmd = CMD_INIT;
      MODE_ALLOC: cmd_o.cmd = ({1'b0, in_item_i.request_size} > 24'(REQ_LIMIT))
                              ? CMD_OOM : CMD_ALLOC;
      MODE_FREE:  cmd_o.cmd = (in_item_i.release_address == '0) ? CMD_NULL : CMD_FREE;
      default:    cmd_o.cmd = CMD_NOP;
    endcase
  end

endmodule

FILE: hw/rtl/ffa_back.sv
// ----------------------------------------------------------------------------
// ffa_back
// executes commands against the block table and drives the result register
// ----------------------------------------------------------------------------
module ffa_back #(
  parameter int unsigned MAX_ENTRIES = ffa_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  ffa_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  input  logic [23:0]        heap_base_i,
  input  logic [23:0]        heap_ceiling_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ffa_pkg::out_item_t out_item_o
);
  import ffa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  bstate_e     state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [CW-1:0] idx_q, idx_d, count_q, count_d;
  logic [23:0] brk_q, brk_d, val_q, val_d, need_q, need_d;
  logic [22:0] size_q, size_d;
  out_item_t   res_q, res_d, out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata, rdata;
  logic [23:0]   aligned, framed;
  logic [24:0]   brk_sum, match_sum;
  logic [23:0]   usable_full;

  ffa_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ENTRIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  ffa_rem #(.UNIT(ALIGN_BYTES)) u_align (
    .value_i   ({1'b0, size_q}),
    .rounded_o (aligned)
  );

  ffa_rem #(.UNIT(FRAME_BYTES)) u_frame (
    .value_i   (val_q),
    .rounded_o (framed)
  );

  assign brk_sum     = {1'b0, brk_q} + {1'b0, need_q};
  assign match_sum   = {1'b0, rdata.base} + 25'(HEADER_BYTES);
  assign usable_full = need_q - 24'(HEADER_BYTES);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    count_d     = count_q;
    brk_d       = brk_q;
    val_d       = val_q;
    need_d      = need_q;
    size_d      = size_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = idx_q[AW-1:0];
    wdata       = rdata;
    unique case (state_q)
      BS_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          res_d = '0;
          size_d = cmd_i.size;
          idx_d = '0;
          unique case (cmd_i.cmd)
            CMD_INIT: begin
              count_d   = '0;
              brk_d     = heap_base_i;
              val_d     = 24'(HEADER_BYTES + INIT_REQUEST);
              state_d   = BS_FRM;
            end
            CMD_ALLOC: state_d = BS_ALN;
            CMD_FREE: state_d = BS_SCAN;
            CMD_OOM: begin
              res_d.status = ST_OOM;
              state_d      = BS_DONE;
            end
            CMD_NULL: begin
              res_d.status = ST_NULL;
              state_d      = BS_DONE;
            end
            default: state_d = BS_DONE;
          endcase
        end
      end
      BS_ALN: begin
        size_d  = aligned[22:0];
        val_d   = aligned + 24'(HEADER_BYTES);
        state_d = BS_SCAN;
      end
      BS_SCAN: begin
        if (idx_q == count_q) begin
          if (cmd_q.cmd == CMD_ALLOC) begin
            state_d   = BS_FRM;
          end else begin
            res_d.status = ST_BADFREE;
            state_d      = BS_DONE;
          end
        end else begin
          state_d = BS_CHK;
        end
      end
      BS_CHK: begin
        if (cmd_q.cmd == CMD_ALLOC) begin
          if (!rdata.used && rdata.usable >= size_q) begin
            we                    = 1'b1;
            wdata.used            = 1'b1;
            res_d.granted_address = match_sum[23:0];
            state_d               = BS_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = BS_SCAN;
          end
        end else begin
          if (rdata.used && match_sum == {1'b0, cmd_q.addr}) begin
            we           = 1'b1;
            wdata.used   = 1'b0;
            res_d.status = ST_OK;
            state_d      = BS_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = BS_SCAN;
          end
        end
      end
      BS_FRM: begin
        need_d  = framed;
        state_d = BS_CARVE;
      end
      BS_CARVE: begin
        if (brk_sum > {1'b0, heap_ceiling_i} || count_q == CW'(MAX_ENTRIES)) begin
          res_d.status = ST_OOM;
        end else begin
          we           = 1'b1;
          waddr        = count_q[AW-1:0];
          wdata.base   = brk_q;
          wdata.usable = usable_full[22:0];
          wdata.used   = (cmd_q.cmd == CMD_ALLOC);
          count_d      = count_q + 1'b1;
          brk_d        = brk_sum[23:0];
          if (cmd_q.cmd == CMD_ALLOC) begin
            res_d.granted_address = brk_q + 24'(HEADER_BYTES);
          end
        end
        state_d = BS_DONE;
      end
      BS_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      count_q     <= '0;
      brk_q       <= HEAP_BASE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      brk_q       <= brk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    val_q  <= val_d;
    need_q <= need_d;
    size_q <= size_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: hw/rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap block allocator with a bump break pointer
// ----------------------------------------------------------------------------
// One transaction is handled at a time by the back end; a two-entry queue lets
// the input side run ahead, and each result waits in an output register. Init
// frames and carves its block at the break; an oversized allocate, a null free
// or the unused mode goes straight to the result. Allocate aligns its size,
// scans the table and marks the first free block that fits, or else frames
// and carves a new block at the break. Free scans the table for the used
// block whose address matches and clears it, or reports a bad free when
// none does. The table scan reads each entry through the registered read port
// of the block-table ram, so MAX_ENTRIES sets the worst case scan length. A
// held-off output keeps the back end in its done state. The table needs no
// clearing pass after reset.
module first_fit_block_allocator #(
  parameter int unsigned MAX_ENTRIES = ffa_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ffa_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ffa_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ffa_pkg::*;

  logic [23:0] heap_base_q, heap_ceil_q;
  logic        push, full, pop, nonempty;
  cmd_t        push_cmd, pop_cmd;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = {1'b0, paddr[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= HEAP_BASE_RST;
      heap_ceil_q <= HEAP_CEIL_RST;
    end else if (psel && penable && pwrite) begin
      if (reg_sel == REG_HEAP_BASE) begin
        heap_base_q <= pwdata[23:0];
      end else begin
        heap_ceil_q <= pwdata[23:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_HEAP_CEIL) ? {8'd0, heap_ceil_q} : {8'd0, heap_base_q};

  ffa_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ffa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .nonempty_o  (nonempty),
    .pop_data_o  (pop_cmd)
  );

  ffa_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (nonempty),
    .cmd_i          (pop_cmd),
    .pop_o          (pop),
    .heap_base_i    (heap_base_q),
    .heap_ceiling_i (heap_ceil_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_o     (out_item_o)
  );

endmodule

FILE: tb/first_fit_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Drives init, allocate, free and unused-mode transactions into the allocator.
// Each result is checked field by field against a heap model in the testbench,
// or the want of a typed directed row. A short directed table leads, then
// random transactions under several register settings and idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module first_fit_block_allocator_tb;
  import ffa_pkg::*;

  localparam int unsigned NUM_BLOCKS  = MAX_ENTRIES_DEF;
  localparam longint unsigned CYCLE_LIMIT = 64'd8000000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // heap model
  logic [23:0] mdl_base_reg = HEAP_BASE_RST;
  logic [23:0] mdl_ceil_reg = HEAP_CEIL_RST;
  logic [23:0] blk_base [NUM_BLOCKS];
  logic [22:0] blk_usable [NUM_BLOCKS];
  logic        blk_used [NUM_BLOCKS];
  int unsigned blk_count = 0;
  logic [23:0] brk_ptr = HEAP_BASE_RST;

  out_item_t   pending_results[$];
  logic [23:0] granted_pool[$];
  int unsigned n_errors = 0;
  longint unsigned n_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  dir_row_t dir_tab[15];

  first_fit_block_allocator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("first_fit_block_allocator_tb: FAIL");
      $finish;
    end
  end

  // carve a block at the break; returns 0 on failure
  function automatic bit carve_at_break(longint unsigned bytes, bit mark_used,
                                        output logic [23:0] where);
    longint unsigned need;
    need = ((HEADER_BYTES + bytes + FRAME_BYTES - 1) / FRAME_BYTES) * FRAME_BYTES;
    where = '0;
    if (longint'(brk_ptr) + need > longint'(mdl_ceil_reg)) return 1'b0;
    if (blk_count >= NUM_BLOCKS) return 1'b0;
    blk_base[blk_count]   = brk_ptr;
    blk_usable[blk_count] = 23'(need - HEADER_BYTES);
    blk_used[blk_count]   = mark_used;
    blk_count++;
    where   = brk_ptr;
    brk_ptr = 24'(longint'(brk_ptr) + need);
    return 1'b1;
  endfunction

  function automatic out_item_t heap_apply(in_item_t it);
    out_item_t res;
    logic [23:0] where;
    longint unsigned size;
    bit found;
    res = '{ST_OK, 24'd0};
    found = 1'b0;
    case (mode_e'(it.mode))
      MODE_INIT: begin
        blk_count = 0;
        brk_ptr = mdl_base_reg;
        if (!carve_at_break(INIT_REQUEST, 1'b0, where)) res.status = ST_OOM;
      end
      MODE_ALLOC: begin
        if (it.request_size > REQ_LIMIT) begin
          res.status = ST_OOM;
        end else begin
          size = ((longint'(it.request_size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
          for (int i = 0; i < blk_count && !found; i++) begin
            if (!blk_used[i] && longint'(blk_usable[i]) >= size) begin
              blk_used[i] = 1'b1;
              res.granted_address = 24'(longint'(blk_base[i]) + HEADER_BYTES);
              found = 1'b1;
            end
          end
          if (!found) begin
            if (carve_at_break(size, 1'b1, where))
              res.granted_address = 24'(longint'(where) + HEADER_BYTES);
            else
              res.status = ST_OOM;
          end
        end
      end
      MODE_FREE: begin
        if (it.release_address == 0) begin
          res.status = ST_NULL;
        end else begin
          res.status = ST_BADFREE;
          for (int i = 0; i < blk_count && !found; i++) begin
            if (blk_used[i] &&
                longint'(blk_base[i]) + HEADER_BYTES == longint'(it.release_address)) begin
              blk_used[i] = 1'b0;
              res.status = ST_OK;
              found = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // receiver stall, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result status=%0d addr=%h", $realtime,
                 out_item_o.status, out_item_o.granted_address);
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (out_item_o.status !== want.status) begin
          n_errors++;
          $display("%0t: status expected %0d actual %0d", $realtime,
                   want.status, out_item_o.status);
        end
        if (out_item_o.granted_address !== want.granted_address) begin
          n_errors++;
          $display("%0t: granted_address expected %h actual %h", $realtime,
                   want.granted_address, out_item_o.granted_address);
        end
      end
    end
  end

  task automatic send_txn(in_item_t it, bit typed, out_item_t want);
    out_item_t res;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    res = heap_apply(it);
    if (it.mode == MODE_ALLOC && res.status == ST_OK)
      granted_pool.push_back(res.granted_address);
    pending_results.push_back(typed ? want : res);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic go_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [23:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 1'b0} << 1;
    pwdata  <= {8'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_HEAP_BASE) mdl_base_reg = value;
    else mdl_ceil_reg = value;
  endtask

  task automatic set_heap(logic [23:0] base, logic [23:0] ceil);
    apb_write(REG_HEAP_BASE, base);
    apb_write(REG_HEAP_CEIL, ceil);
    @(posedge clk_i);
  endtask

  function automatic in_item_t random_txn();
    in_item_t it;
    int unsigned roll;
    it.request_size    = 23'($urandom);
    it.release_address = 24'($urandom);
    roll = $urandom_range(99);
    if (roll < 4) it.mode = MODE_INIT;
    else if (roll < 52) it.mode = MODE_ALLOC;
    else if (roll < 96) it.mode = MODE_FREE;
    else it.mode = MODE_NONE;
    roll = $urandom_range(99);
    if (roll < 88) it.request_size = 23'($urandom_range(0, 20000));
    else if (roll < 95) it.request_size = 23'($urandom_range(0, REQ_LIMIT));
    roll = $urandom_range(99);
    if (roll < 75 && granted_pool.size() != 0)
      it.release_address = granted_pool[$urandom_range(granted_pool.size() - 1)];
    else if (roll < 82)
      it.release_address = '0;
    return it;
  endfunction

  task automatic random_phase(int unsigned n_items, int unsigned idle_pct,
                              int unsigned stall_pct, int unsigned hold);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    hold_req        = hold;
    granted_pool.delete();
    send_txn('{MODE_INIT, 23'd0, 24'd0}, 1'b0, '0);
    for (int n = 0; n < n_items; n++) begin
      send_txn(random_txn(), 1'b0, '0);
      if (granted_pool.size() > 40) void'(granted_pool.pop_front());
    end
    go_quiet();
  endtask

  initial begin
    dir_tab[0]  = '{'{MODE_ALLOC, 23'd0,       24'd0},       1, '{ST_OK, 24'h40000C}};
    dir_tab[1]  = '{'{MODE_FREE,  23'd0,       24'd0},       1, '{ST_NULL, 24'd0}};
    dir_tab[2]  = '{'{MODE_FREE,  23'd0,       24'h000123},  1, '{ST_BADFREE, 24'd0}};
    dir_tab[3]  = '{'{MODE_NONE,  23'h7FFFFF,  24'hFFFFFF},  1, '{ST_OK, 24'd0}};
    dir_tab[4]  = '{'{MODE_INIT,  23'd0,       24'd0},       1, '{ST_OK, 24'd0}};
    dir_tab[5]  = '{'{MODE_ALLOC, 23'd8180,    24'd0},       0, '0};
    dir_tab[6]  = '{'{MODE_ALLOC, 23'd1,       24'd0},       1, '{ST_OK, 24'h40000C}};
    dir_tab[7]  = '{'{MODE_ALLOC, 23'd4194305, 24'd0},       1, '{ST_OOM, 24'd0}};
    dir_tab[8]  = '{'{MODE_ALLOC, 23'd4194304, 24'd0},       1, '{ST_OOM, 24'd0}};
    dir_tab[9]  = '{'{MODE_FREE,  23'd0,       24'h40000C},  1, '{ST_OK, 24'd0}};
    dir_tab[10] = '{'{MODE_FREE,  23'd0,       24'h40000C},  1, '{ST_BADFREE, 24'd0}};
    dir_tab[11] = '{'{MODE_FREE,  23'h7FFFFF,  24'hFFFFFF},  1, '{ST_BADFREE, 24'd0}};
    dir_tab[12] = '{'{MODE_ALLOC, 23'h7FFFFF,  24'd0},       1, '{ST_OOM, 24'd0}};
    dir_tab[13] = '{'{MODE_ALLOC, 23'd8,       24'd0},       1, '{ST_OK, 24'h40000C}};
    dir_tab[14] = '{'{MODE_ALLOC, 23'd12000,   24'd0},       0, '0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) send_txn(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
    go_quiet();

    // init that cannot carve its block
    set_heap(24'hFFFFFF, 24'hFFFFFF);
    send_txn('{MODE_INIT, 23'd0, 24'd0}, 1'b1, '{ST_OOM, 24'd0});
    send_txn('{MODE_ALLOC, 23'd8, 24'd0}, 1'b1, '{ST_OOM, 24'd0});
    go_quiet();
    set_heap(24'h000000, 24'h000000);
    send_txn('{MODE_INIT, 23'd0, 24'd0}, 1'b1, '{ST_OOM, 24'd0});
    go_quiet();

    set_heap(HEAP_BASE_RST, HEAP_CEIL_RST);
    random_phase(140, 0, 0, 2500);
    set_heap(24'h000000, 24'hFFFFFF);
    random_phase(140, 80, 0, 0);
    set_heap(24'h100000, 24'h118000);
    random_phase(140, 0, 80, 0);
    set_heap(24'hABC000, 24'hFFFFFF);
    random_phase(140, 37, 37, 0);
    repeat (300) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("first_fit_block_allocator_tb: PASS");
    end else begin
      $display("first_fit_block_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
